### rtl/wildcard_byte_pattern_search_defines.svh
// Assertion macros shared by the checker of the pattern search block.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WBPS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WBPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

   // Positions that the pattern registers can describe.
   localparam int PAT_POS = 16;
   localparam int PAT_POS_BITS = 4;
   localparam int SPAN_BITS = 5;
   localparam int BYTE_W = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int MATCH_OFFSET_W = 32;

   localparam int PATTERN_MAX_DEF = 16;
   localparam int OFFSET_BITS_DEF = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_CARE_MASK    = 2'd2
   } csr_index_type;

   // Pattern aligned to the window: entry k is compared with the byte k places
   // back from the newest one.
   typedef struct packed {
      logic [PAT_POS-1:0][BYTE_W-1:0] pat;
      logic [PAT_POS-1:0]             care;
      logic [SPAN_BITS-1:0]           span;
   } align_type;

endpackage

`default_nettype wire

### rtl/wbps_req_if.sv
`default_nettype none

interface wbps_req_if;
   logic                         valid;
   logic                         ready;
   logic [wbps_pkg::BYTE_W-1:0]  data_byte;
   logic                         last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/wbps_rsp_if.sv
`default_nettype none

interface wbps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [wbps_pkg::MATCH_OFFSET_W-1:0] match_offset;

   modport source (output valid, output match_offset, input ready);
   modport sink (input valid, input match_offset, output ready);
endinterface

`default_nettype wire

### rtl/wbps_csr_if.sv
`default_nettype none

interface wbps_csr_if;
   logic                             valid;
   logic                             ready;
   logic [wbps_pkg::CSR_INDEX_W-1:0] index;
   logic [wbps_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/wbps_cell.sv
`default_nettype none

// One window position: holds a byte, hands it on, and checks the byte it is
// about to take against its aligned pattern byte.
module wbps_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        shift_en,
   input  wire logic [wbps_pkg::BYTE_W-1:0] byte_in,
   input  wire logic [wbps_pkg::BYTE_W-1:0] pat_byte,
   input  wire logic                        care_bit,
   output logic      [wbps_pkg::BYTE_W-1:0] byte_out,
   output logic                             hit
);

   logic [wbps_pkg::BYTE_W-1:0] byte_ff;
   logic [wbps_pkg::BYTE_W-1:0] byte_in_w;

   assign byte_in_w = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in_w;
      end
   end

   assign byte_out = byte_ff;
   assign hit = !care_bit || (byte_in == pat_byte);

endmodule

`default_nettype wire

### rtl/wbps_align.sv
`default_nettype none

// Finds the pattern span and lines the pattern up with the window cells.
module wbps_align #(
   parameter int CELLS = wbps_pkg::PAT_POS
) (
   input  wire logic [wbps_pkg::CSR_DATA_W-1:0] pattern_low,
   input  wire logic [wbps_pkg::CSR_DATA_W-1:0] pattern_high,
   input  wire logic [wbps_pkg::PAT_POS-1:0]    care_mask,
   output wbps_pkg::align_type                  align
);

   logic [wbps_pkg::PAT_POS-1:0][wbps_pkg::BYTE_W-1:0] pat_bytes;
   logic [wbps_pkg::PAT_POS-1:0]                       eff_care;
   logic [wbps_pkg::SPAN_BITS-1:0]                     span;

   assign pat_bytes = {pattern_high, pattern_low};

   always_comb begin
      for (int i = 0; i < wbps_pkg::PAT_POS; i++) begin
         eff_care[i] = care_mask[i] && (i < CELLS);
      end
   end

   always_comb begin
      span = '0;
      for (int i = 0; i < wbps_pkg::PAT_POS; i++) begin
         if (eff_care[i]) begin
            span = wbps_pkg::SPAN_BITS'(i + 1);
         end
      end
   end

   always_comb begin
      logic [wbps_pkg::SPAN_BITS-1:0] idx;
      align.span = span;
      for (int k = 0; k < wbps_pkg::PAT_POS; k++) begin
         idx = span - wbps_pkg::SPAN_BITS'(1) - wbps_pkg::SPAN_BITS'(k);
         if (wbps_pkg::SPAN_BITS'(k) < span) begin
            align.pat[k]  = pat_bytes[idx[wbps_pkg::PAT_POS_BITS-1:0]];
            align.care[k] = eff_care[idx[wbps_pkg::PAT_POS_BITS-1:0]];
         end else begin
            align.pat[k]  = '0;
            align.care[k] = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/wbps_out_buf.sv
`default_nettype none

// Two-entry result buffer between the compare and the result channel.
module wbps_out_buf (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   input  wire logic [wbps_pkg::MATCH_OFFSET_W-1:0] push_data,
   output logic                                     full,
   wbps_rsp_if.source                               rsp
);

   logic [1:0]                          count_ff, count_in;
   logic [wbps_pkg::MATCH_OFFSET_W-1:0] head_ff, head_in;
   logic [wbps_pkg::MATCH_OFFSET_W-1:0] tail_ff, tail_in;
   logic                                pop;

   assign pop = rsp.valid && rsp.ready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign full             = (count_ff == 2'd2);
   assign rsp.valid        = (count_ff != 2'd0);
   assign rsp.match_offset = head_ff;

endmodule

`default_nettype wire

### rtl/wildcard_byte_pattern_search.sv
// Streaming byte pattern search with wildcard positions.
// The req channel carries one byte of the scanned sequence per transfer, with
// last_byte marking the final byte; the position count restarts after it.
// The csr channel writes the pattern bytes (index 0: bytes 0 to 7, index 1:
// bytes 8 to 15) and the care mask (index 2); other indexes are ignored.
// Always ready; the user must write it only while the block is idle (unchecked).
// Each byte that completes a matching window yields one rsp transfer with the
// start offset of that window; overlapping matches are all reported.
// A match is registered on its req transfer and offered on rsp after older results.
// Throughput is one byte per cycle while req.ready is high: a chain of byte cells
// shifts on each req transfer and every cell compares in parallel, so the whole
// window check happens in the cycle of the transfer.
// Results sit in a two-entry buffer, so req keeps flowing while a result waits.
// req.ready falls only when both entries hold results that rsp has not taken.
// Reset clears the registers, the window and the position count; the block
// takes bytes in the first cycle after reset.
`default_nettype none

module wildcard_byte_pattern_search #(
   parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
   parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   wbps_req_if.sink   req,
   wbps_rsp_if.source rsp,
   wbps_csr_if.sink   csr
);

   // Only positions within PATTERN_MAX and covered by the pattern registers take part in the compare.
   localparam int CELLS =
      (PATTERN_MAX < wbps_pkg::PAT_POS) ? PATTERN_MAX : wbps_pkg::PAT_POS;
   localparam int WIDE_W =
      (OFFSET_BITS > wbps_pkg::MATCH_OFFSET_W) ? OFFSET_BITS : wbps_pkg::MATCH_OFFSET_W;

   logic [wbps_pkg::CSR_DATA_W-1:0] pattern_low_ff, pattern_low_in;
   logic [wbps_pkg::CSR_DATA_W-1:0] pattern_high_ff, pattern_high_in;
   logic [wbps_pkg::PAT_POS-1:0]    care_ff, care_in;
   logic [OFFSET_BITS-1:0]          position_ff, position_in;

   wbps_pkg::align_type            align;
   logic                           accept;
   logic                           buf_full;
   logic [CELLS-1:0]               hits;
   logic [CELLS-1:0][wbps_pkg::BYTE_W-1:0] cell_bytes;
   logic [wbps_pkg::SPAN_BITS-1:0] span_m1;
   logic                           long_enough;
   logic                           match;
   logic [OFFSET_BITS-1:0]         diff;
   logic [WIDE_W-1:0]              diff_ext;

   // Configuration registers. The csr channel never stalls.
   assign csr.ready = 1'b1;

   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      care_in         = care_ff;
      if (csr.valid) begin
         case (csr.index)
            wbps_pkg::CSR_PATTERN_LOW:  pattern_low_in  = csr.data;
            wbps_pkg::CSR_PATTERN_HIGH: pattern_high_in = csr.data;
            wbps_pkg::CSR_CARE_MASK:    care_in = csr.data[wbps_pkg::PAT_POS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_ff         <= '0;
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         care_ff         <= care_in;
      end
   end

   // The user must keep the configuration still while bytes flow (the block does
   // not enforce this), so the aligned pattern is a static input to the cells.
   wbps_align #(
      .CELLS (CELLS)
   ) u_align (
      .pattern_low  (pattern_low_ff),
      .pattern_high (pattern_high_ff),
      .care_mask    (care_ff),
      .align        (align)
   );

   assign req.ready = !buf_full;
   assign accept    = req.valid && req.ready;

   // Window cells: cell 0 takes the incoming byte, cell k the byte of cell k-1.
   // Each cell checks the byte it is about to hold, so the hit vector describes
   // the window as it stands after this transfer.
   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      logic [wbps_pkg::BYTE_W-1:0] byte_in;
      if (k == 0) begin : g_head
         assign byte_in = req.data_byte;
      end else begin : g_body
         assign byte_in = cell_bytes[k-1];
      end
      wbps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .byte_in  (byte_in),
         .pat_byte (align.pat[k]),
         .care_bit (align.care[k]),
         .byte_out (cell_bytes[k]),
         .hit      (hits[k])
      );
   end

   // A window counts only once the current sequence has filled it, so bytes of
   // an earlier sequence never take part. An empty care mask gives span zero
   // and never matches.
   assign span_m1     = align.span - wbps_pkg::SPAN_BITS'(1);
   assign long_enough = (position_ff >= OFFSET_BITS'(span_m1));
   assign match       = (align.span != '0) && long_enough && (&hits);

   // Start offset of the window; it wraps to the result width.
   assign diff     = position_ff - OFFSET_BITS'(span_m1);
   assign diff_ext = WIDE_W'(diff);

   // Position of the next byte: restarts after the last byte of a sequence and
   // saturates at its largest value.
   always_comb begin
      position_in = position_ff;
      if (accept) begin
         if (req.last_byte) begin
            position_in = '0;
         end else if (position_ff != '1) begin
            position_in = position_ff + OFFSET_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else begin
         position_ff <= position_in;
      end
   end

   wbps_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && match),
      .push_data (diff_ext[wbps_pkg::MATCH_OFFSET_W-1:0]),
      .full      (buf_full),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

### rtl/wbps_checker.sv
`default_nettype none

`include "wildcard_byte_pattern_search_defines.svh"

module wbps_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic csr_ready
);

   `WBPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped while stalled")

   `WBPS_ASSERT_IMPL(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready), "result without a byte transfer")

   `WBPS_ASSERT_IMPL(a_stall_cause, clock, reset, !req_ready, rsp_valid, "req stalled with no result pending")

   `WBPS_ASSERT_NEXT(a_stall_keep, clock, reset, !req_ready && !rsp_ready, !req_ready, "full buffer emptied without a transfer")

   `WBPS_ASSERT_IMPL(a_csr_ready, clock, reset, 1'b1, csr_ready, "csr channel stalled")

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .csr_ready (csr.ready)
);

`default_nettype wire
